FILE: rtl/ppp_pkg.sv
`default_nettype none

package ppp_pkg;

  // Fixed field widths and fixed-point positions
  localparam int unsigned IN_W          = 32;
  localparam int unsigned OUT_W         = 32;
  localparam int unsigned CFG_W         = 64;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned COEFF_FIELD_W = 16;
  localparam int unsigned COEFF_FRAC    = 12;
  localparam int unsigned SCALE_W       = 16;
  localparam int unsigned SCALE_FRAC    = 8;
  localparam int unsigned Q_FRAC        = 16;
  localparam int unsigned PROJ_LIM_SH   = 46;
  localparam int unsigned PROJ_W        = PROJ_LIM_SH + 2;
  localparam int unsigned IN_DATA_W     = 4 * IN_W;
  localparam int unsigned OUT_DATA_W    = 8 * OUT_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_W = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd3;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SDIV_START,
    OP_SDIV_WRITE,
    OP_MUL,
    OP_ACC,
    OP_PDIV_START,
    OP_PDIV_WRITE,
    OP_PCLAMP,
    OP_FMUL,
    OP_FWRITE,
    OP_UPDATE
  } ppp_op_e;

  typedef struct packed {
    ppp_op_e    op;
    logic [1:0] sel;   // coordinate or matrix row
    logic [1:0] idx;   // vector element
  } ppp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic w_zero;
  } ppp_status_t;

endpackage

`default_nettype wire

FILE: rtl/ppp_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module ppp_div #(
  parameter int unsigned NW = 54,
  parameter int unsigned DW = 38
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o,
  output logic               done_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   a_q, a_d;
  logic [DW-1:0]   r_q, r_d;
  logic [DW-1:0]   den_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;
  logic [DW:0]     diff;

  always_comb begin
    trial  = {r_q, a_q[NW-1]};
    diff   = trial - {1'b0, den_q};
    a_d    = a_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = num_i;
      r_d    = '0;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        r_d = diff[DW-1:0];
        a_d = {a_q[NW-2:0], 1'b1};
      end else begin
        r_d = trial[DW-1:0];
        a_d = {a_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    r_q <= r_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o  = a_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/ppp_datapath.sv
`default_nettype none

module ppp_datapath #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned COEFF_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ppp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ppp_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic [ppp_pkg::IN_DATA_W-1:0]    in_data_i,
  input  wire logic                             in_last_i,
  input  wire ppp_pkg::ppp_cmd_t                cmd_i,
  output ppp_pkg::ppp_status_t                  status_o,
  output logic      [ppp_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                                  out_sat_o,
  output logic                                  out_last_o
);

  import ppp_pkg::*;

  localparam int unsigned VW  = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;
  localparam int unsigned AW  = COEFF_BITS + VW - COEFF_FRAC + 2;
  localparam int unsigned NW  = AW + Q_FRAC;
  localparam int unsigned DW  = AW;
  localparam int unsigned SQW = IN_W + SCALE_FRAC + 1;
  localparam int unsigned CW  = ((COORD_BITS > SQW) ? COORD_BITS : SQW) + 1;
  localparam int unsigned SCW = SCALE_W + 1;
  localparam int unsigned MA  = (COEFF_BITS > SCW) ? COEFF_BITS : SCW;
  localparam int unsigned MB  = (VW > PROJ_W) ? VW : PROJ_W;
  localparam int unsigned MP  = MA + MB;
  localparam int unsigned CLW = (AW > PROJ_W) ? AW : PROJ_W;

  // Configuration
  logic [CFG_W-1:0]   row_x_q, row_y_q, row_w_q;
  logic [SCALE_W-1:0] scale_q;

  // Item working set
  logic signed [IN_W-1:0]   vin_q [4];
  logic                     last_q;
  logic signed [VW-1:0]     v_q   [3];
  logic signed [AW-1:0]     acc_q [3];
  logic signed [PROJ_W-1:0] p_q   [2];
  logic signed [OUT_W-1:0]  f_q   [2];
  logic signed [MP-1:0]     prod_q;
  logic                     sat_q;

  // Shape state
  logic signed [OUT_W-1:0] prev_q [2];
  logic signed [OUT_W-1:0] bbox_q [4];
  logic                    at_start_q;

  // Result register
  logic [OUT_DATA_W-1:0] o_data_q;
  logic                  o_sat_q, o_last_q;

  logic [SCALE_W-1:0]       s_eff;
  logic [CFG_W-1:0]         row_sel;
  logic signed [MA-1:0]     ma;
  logic signed [MB-1:0]     mb;
  logic signed [IN_W-1:0]   xs;
  logic [IN_W-1:0]          xabs;
  logic signed [AW-1:0]     acc_sel;
  logic [AW-1:0]            aabs, wabs;
  logic                     div_start;
  logic [NW-1:0]            div_num, div_quo;
  logic [DW-1:0]            div_den;
  logic                     div_done;

  logic [CW-1:0]            sq;
  logic signed [CW-1:0]     sv, shi, slo, sclamp;
  logic                     ssat;
  logic [NW-1:0]            limq, qc;
  logic                     pover, pneg;
  logic [PROJ_W-1:0]        qct;
  logic signed [PROJ_W-1:0] pv;
  logic signed [CLW-1:0]    ax, climp, climn, cv;
  logic                     csat;
  logic signed [MP-1:0]     fsh, fhi, flo, fv;
  logic                     fsat;
  logic signed [OUT_W-1:0]  px, py, sx, sy;
  logic signed [OUT_W-1:0]  bmin_x, bmax_x, bmin_y, bmax_y;

  assign s_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;

  always_comb begin
    unique case (cmd_i.sel)
      2'd0:    row_sel = row_x_q;
      2'd1:    row_sel = row_y_q;
      default: row_sel = row_w_q;
    endcase
  end

  // Multiplier operand selection
  always_comb begin
    if (cmd_i.op == OP_FMUL) begin
      ma = MA'(signed'({1'b0, s_eff}));
      mb = MB'(p_q[cmd_i.sel[0]]);
    end else begin
      ma = MA'(signed'(row_sel[{cmd_i.idx, 4'b0000} +: COEFF_BITS]));
      case (cmd_i.idx)
        2'd0:    mb = MB'(v_q[0]);
        2'd1:    mb = MB'(v_q[1]);
        2'd2:    mb = MB'(v_q[2]);
        default: mb = MB'(vin_q[3]);
      endcase
    end
  end

  // Divider operands
  always_comb begin
    case (cmd_i.sel)
      2'd0:    xs = vin_q[0];
      2'd1:    xs = vin_q[1];
      default: xs = vin_q[2];
    endcase
    case (cmd_i.sel)
      2'd0:    acc_sel = acc_q[0];
      2'd1:    acc_sel = acc_q[1];
      default: acc_sel = acc_q[2];
    endcase
    xabs      = xs[IN_W-1] ? -xs : xs;
    aabs      = acc_sel[AW-1] ? -acc_sel : acc_sel;
    wabs      = acc_q[2][AW-1] ? -acc_q[2] : acc_q[2];
    div_start = (cmd_i.op == OP_SDIV_START) || (cmd_i.op == OP_PDIV_START);
    if (cmd_i.op == OP_SDIV_START) begin
      div_num = NW'({xabs, {SCALE_FRAC{1'b0}}});
      div_den = DW'(s_eff);
    end else begin
      div_num = {aabs, {Q_FRAC{1'b0}}};
      div_den = wabs;
    end
  end

  ppp_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // Input scaling result: sign and clamp to the coordinate range
  always_comb begin
    sq     = div_quo[CW-1:0];
    sv     = xs[IN_W-1] ? -signed'(sq) : signed'(sq);
    shi    = signed'({{(CW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}});
    slo    = ~shi;
    ssat   = (sv > shi) || (sv < slo);
    sclamp = (sv > shi) ? shi : ((sv < slo) ? slo : sv);
  end

  // Perspective quotient: limit magnitude, apply sign
  always_comb begin
    limq  = NW'(1) << PROJ_LIM_SH;
    pover = div_quo > limq;
    qc    = pover ? limq : div_quo;
    qct   = qc[PROJ_W-1:0];
    pneg  = acc_sel[AW-1] ^ acc_q[2][AW-1];
    pv    = pneg ? -signed'(qct) : signed'(qct);
  end

  // Undivided value when w is zero
  always_comb begin
    ax    = CLW'(acc_sel);
    climp = signed'(CLW'(1) << PROJ_LIM_SH);
    climn = -climp;
    csat  = (ax > climp) || (ax < climn);
    cv    = (ax > climp) ? climp : ((ax < climn) ? climn : ax);
  end

  // Scale back to output range
  always_comb begin
    fsh  = prod_q >>> SCALE_FRAC;
    fhi  = signed'({{(MP - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}});
    flo  = ~fhi;
    fsat = (fsh > fhi) || (fsh < flo);
    fv   = (fsh > fhi) ? fhi : ((fsh < flo) ? flo : fsh);
  end

  // Segment and box for this vertex
  always_comb begin
    px = f_q[0];
    py = f_q[1];
    if (at_start_q) begin
      sx = px; sy = py;
      bmin_x = px; bmax_x = px; bmin_y = py; bmax_y = py;
    end else begin
      sx = prev_q[0]; sy = prev_q[1];
      bmin_x = (px < bbox_q[0]) ? px : bbox_q[0];
      bmax_x = (px > bbox_q[1]) ? px : bbox_q[1];
      bmin_y = (py < bbox_q[2]) ? py : bbox_q[2];
      bmax_y = (py > bbox_q[3]) ? py : bbox_q[3];
    end
  end

  // Configuration, saturation flag and shape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q    <= CFG_W'(64'h0000_0000_0000_1000);
      row_y_q    <= CFG_W'(64'h0000_0000_1000_0000);
      row_w_q    <= CFG_W'(64'h1000_0000_0000_0000);
      scale_q    <= SCALE_W'(16'h0100);
      at_start_q <= 1'b1;
      prev_q[0]  <= '0;
      prev_q[1]  <= '0;
      for (int i = 0; i < 4; i++) begin
        bbox_q[i] <= '0;
      end
      sat_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROW_X: row_x_q <= cfg_data_i;
          CFG_ROW_Y: row_y_q <= cfg_data_i;
          CFG_ROW_W: row_w_q <= cfg_data_i;
          CFG_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
          default:   ;
        endcase
      end
      case (cmd_i.op)
        OP_LOAD:       sat_q <= 1'b0;
        OP_SDIV_WRITE: sat_q <= sat_q | ssat;
        OP_PDIV_WRITE: sat_q <= sat_q | pover;
        OP_PCLAMP:     sat_q <= sat_q | csat;
        OP_FWRITE:     sat_q <= sat_q | fsat;
        OP_UPDATE: begin
          at_start_q <= last_q;
          prev_q[0]  <= px;
          prev_q[1]  <= py;
          bbox_q[0]  <= bmin_x;
          bbox_q[1]  <= bmax_x;
          bbox_q[2]  <= bmin_y;
          bbox_q[3]  <= bmax_y;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        for (int i = 0; i < 4; i++) begin
          vin_q[i] <= signed'(in_data_i[i*IN_W +: IN_W]);
        end
        last_q <= in_last_i;
        for (int i = 0; i < 3; i++) begin
          acc_q[i] <= '0;
        end
      end
      OP_SDIV_WRITE: v_q[cmd_i.sel] <= VW'(sclamp);
      OP_MUL, OP_FMUL: prod_q <= ma * mb;
      OP_ACC: acc_q[cmd_i.sel] <= acc_sel + AW'(prod_q >>> COEFF_FRAC);
      OP_PDIV_WRITE: p_q[cmd_i.sel[0]] <= pv;
      OP_PCLAMP: p_q[cmd_i.sel[0]] <= PROJ_W'(cv);
      OP_FWRITE: f_q[cmd_i.sel[0]] <= OUT_W'(fv);
      OP_UPDATE: begin
        o_data_q <= {bmax_y, bmin_y, bmax_x, bmin_x, py, px, sy, sx};
        o_sat_q  <= sat_q;
        o_last_q <= last_q;
      end
      default: ;
    endcase
  end

  assign status_o.div_done = div_done;
  assign status_o.w_zero   = (acc_q[2] == '0);
  assign out_data_o        = o_data_q;
  assign out_sat_o         = o_sat_q;
  assign out_last_o        = o_last_q;

endmodule

`default_nettype wire

FILE: rtl/ppp_ctrl.sv
`default_nettype none

module ppp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire ppp_pkg::ppp_status_t status_i,
  output ppp_pkg::ppp_cmd_t         cmd_o
);

  import ppp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SDIV_GO,
    S_SDIV_WAIT,
    S_MUL,
    S_ACC,
    S_PDIV_GO,
    S_PDIV_WAIT,
    S_FMUL,
    S_FACC,
    S_UPD
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic [1:0] idx_q, idx_d;
  logic       oval_q, oval_d;

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    idx_d     = idx_q;
    oval_d    = oval_q && !out_ready_i;
    cmd_o.op  = OP_NONE;
    cmd_o.sel = sel_q;
    cmd_o.idx = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          sel_d    = 2'd0;
          state_d  = S_SDIV_GO;
        end
      end
      S_SDIV_GO: begin
        cmd_o.op = OP_SDIV_START;
        state_d  = S_SDIV_WAIT;
      end
      S_SDIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_SDIV_WRITE;
          if (sel_q == 2'd2) begin
            sel_d   = 2'd0;
            idx_d   = 2'd0;
            state_d = S_MUL;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = S_SDIV_GO;
          end
        end
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = S_MUL;
        idx_d    = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          if (sel_q == 2'd2) begin
            sel_d   = 2'd0;
            state_d = S_PDIV_GO;
          end else begin
            sel_d = sel_q + 2'd1;
          end
        end
      end
      S_PDIV_GO: begin
        if (status_i.w_zero) begin
          cmd_o.op = OP_PCLAMP;
          sel_d    = 2'd1;
          state_d  = (sel_q == 2'd1) ? S_FMUL : S_PDIV_GO;
          if (sel_q == 2'd1) begin
            sel_d = 2'd0;
          end
        end else begin
          cmd_o.op = OP_PDIV_START;
          state_d  = S_PDIV_WAIT;
        end
      end
      S_PDIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_PDIV_WRITE;
          if (sel_q == 2'd1) begin
            sel_d   = 2'd0;
            state_d = S_FMUL;
          end else begin
            sel_d   = 2'd1;
            state_d = S_PDIV_GO;
          end
        end
      end
      S_FMUL: begin
        cmd_o.op = OP_FMUL;
        state_d  = S_FACC;
      end
      S_FACC: begin
        cmd_o.op = OP_FWRITE;
        if (sel_q == 2'd1) begin
          state_d = S_UPD;
        end else begin
          sel_d   = 2'd1;
          state_d = S_FMUL;
        end
      end
      S_UPD: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.op = OP_UPDATE;
          oval_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= '0;
      idx_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      idx_q   <= idx_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;

endmodule

`default_nettype wire

FILE: rtl/polyline_perspective_projector.sv
`default_nettype none

// Perspective projector for polylines. Each input item is one homogeneous
// vertex (x, y, z, w in signed Q16.16, tlast closing the shape). x, y and z
// are divided by the Q8.8 view scale, three programmable Q4.12 matrix rows
// give projected X, Y and W, X and Y are divided by W (skipped when W is
// zero) and scaled back by the view scale. Each vertex yields one result: the
// segment from the previous projected vertex to this one (zero length for the
// first vertex of a shape) and the running bounding box of the shape; tuser
// flags any clamping. One vertex is in flight at a time. The work runs on the
// shared bit-serial divider, which does three input scalings and two
// perspective divisions per vertex (the perspective divisions are skipped
// when W is zero), and on the one shared multiplier for the twelve matrix
// products and two output scalings. The next vertex is taken while the
// previous result still waits on the output register. Write the
// configuration only while the block is idle.
module polyline_perspective_projector #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned COEFF_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [ppp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ppp_pkg::CFG_W-1:0]      cfg_data_i,
  // Vertex stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // vertex_x, vertex_y, vertex_z, vertex_w
  input  wire logic [ppp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                           s_axis_tlast,   // end_of_shape
  // Segment and box stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
  // box_min_x, box_max_x, box_min_y, box_max_y
  output logic      [ppp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                                m_axis_tuser,   // saturated
  output logic                                m_axis_tlast    // shape_done
);

  import ppp_pkg::*;

  ppp_cmd_t    cmd;
  ppp_status_t status;

  // Sequence the work for one vertex
  ppp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold configuration, shape state, the arithmetic and the result register
  ppp_datapath #(
    .COORD_BITS (COORD_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (m_axis_tdata),
    .out_sat_o  (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/ppp_checker.sv
`default_nettype none

module ppp_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [255:0] m_axis_tdata
);

  logic signed [31:0] end_x, end_y, min_x, max_x, min_y, max_y;

  assign end_x = m_axis_tdata[95:64];
  assign end_y = m_axis_tdata[127:96];
  assign min_x = m_axis_tdata[159:128];
  assign max_x = m_axis_tdata[191:160];
  assign min_y = m_axis_tdata[223:192];
  assign max_y = m_axis_tdata[255:224];

  // One vertex at a time: input closes after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a vertex is in work");

  // Box is well formed
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (min_x <= max_x) && (min_y <= max_y))
    else $error("bounding box min above max");

  // Box holds the segment end
  a_box_holds_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (min_x <= end_x) && (end_x <= max_x) &&
                      (min_y <= end_y) && (end_y <= max_y))
    else $error("segment end outside bounding box");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind polyline_perspective_projector ppp_checker u_ppp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: test/tb_polyline_perspective_projector.sv
`timescale 1ns / 100ps

module tb_polyline_perspective_projector;
  import ppp_pkg::*;

  localparam int unsigned N_DIRECTED  = 11;
  localparam int unsigned N_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS = 174;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam longint      CYCLE_LIMIT = 3_000_000;
  localparam longint      PROJ_LIM    = longint'(1) << 46;
  localparam longint      I32_MAX     = longint'(2147483647);
  localparam longint      I32_MIN     = -I32_MAX - 1;
  localparam logic [31:0] ONE         = 32'h0001_0000;

  // One result item as it leaves the block: segment and box in tdata order
  // (seg_start_x in f[0] up to box_max_y in f[7]), then tuser, then tlast.
  typedef struct packed {
    logic [7:0][31:0] f;
    logic             sat;
    logic             done;
  } seg_box_t;

  typedef struct {
    logic [31:0]  x, y, z, w;
    logic         last;
    bit           typed;   // expectation written out below rather than predicted
    logic [255:0] tdata;   // box_max_y .. seg_start_x, highest field first
    logic         sat;
  } vertex_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_ROW_X;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  polyline_perspective_projector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the configuration registers, reset values first
  logic [63:0] row_x_sh = 64'd4096;
  logic [63:0] row_y_sh = 64'd268435456;
  logic [63:0] row_w_sh = 64'd1152921504606846976;
  logic [15:0] scale_sh = 16'd256;

  // Shadow of the shape state
  longint      prev_px, prev_py;
  bit          shape_fresh = 1'b1;
  longint      bbox[4];

  seg_box_t    pending_segs[$];
  int          errors = 0;
  longint      cycles = 0;
  int          burst_left = 0;
  int          holdoff_req = 0;
  int          holdoff_served = 0;
  int          hold_left = 0;
  int          ready_pct = 100;
  int          pattern_left = 0;
  vertex_row_t dir_rows[N_DIRECTED];
  string       field_name[8] = '{"seg_start_x", "seg_start_y", "seg_end_x", "seg_end_y",
                                 "box_min_x", "box_max_x", "box_min_y", "box_max_y"};

  task automatic report(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Projection arithmetic
  // ---------------------------------------------------------------------------
  function automatic longint clamp_to(input longint v, input longint lo, input longint hi,
                                      inout bit sat);
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Q4.12 coefficient k of a matrix row, sign extended
  function automatic longint coef_of(input logic [63:0] row, input int k);
    logic [15:0] c;
    c = row[16*k +: 16];
    return longint'($signed(c));
  endfunction

  // Each product is floored to Q16.16 before the exact sum
  function automatic longint row_dot(input logic [63:0] row,
                                     input longint v0, v1, v2, v3);
    return ((coef_of(row, 0) * v0) >>> 12) + ((coef_of(row, 1) * v1) >>> 12) +
           ((coef_of(row, 2) * v2) >>> 12) + ((coef_of(row, 3) * v3) >>> 12);
  endfunction

  // num * 2^16 / den toward zero, magnitude clamped to 2^46
  function automatic longint persp_div(input longint num, input longint den, inout bit sat);
    bit     neg;
    longint a, b, q;
    neg = (num < 0) != (den < 0);
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    q = (a << 16) / b;
    if (q > PROJ_LIM) begin
      sat = 1'b1;
      q = PROJ_LIM;
    end
    return neg ? -q : q;
  endfunction

  function automatic longint rescale_out(input longint p, input longint s, inout bit sat);
    longint t;
    t = clamp_to(p, -PROJ_LIM, PROJ_LIM, sat);
    return clamp_to((t * s) >>> 8, I32_MIN, I32_MAX, sat);
  endfunction

  // Project one vertex and advance the shape state
  task automatic project_vertex(input logic [31:0] x, y, z, w, input logic last,
                                output seg_box_t r);
    longint s, xs, ys, zs, ws, px_q, py_q, w_q, px, py, sx, sy;
    bit     sat;
    sat = 1'b0;
    s = (scale_sh == 16'd0) ? 1 : longint'(scale_sh);
    xs = clamp_to(longint'($signed(x)) * 256 / s, I32_MIN, I32_MAX, sat);
    ys = clamp_to(longint'($signed(y)) * 256 / s, I32_MIN, I32_MAX, sat);
    zs = clamp_to(longint'($signed(z)) * 256 / s, I32_MIN, I32_MAX, sat);
    ws = longint'($signed(w));
    px_q = row_dot(row_x_sh, xs, ys, zs, ws);
    py_q = row_dot(row_y_sh, xs, ys, zs, ws);
    w_q  = row_dot(row_w_sh, xs, ys, zs, ws);
    // zero W: skip the perspective division
    if (w_q != 0) begin
      px_q = persp_div(px_q, w_q, sat);
      py_q = persp_div(py_q, w_q, sat);
    end
    px = rescale_out(px_q, s, sat);
    py = rescale_out(py_q, s, sat);
    if (shape_fresh) begin
      // first vertex of a shape: zero-length segment, box collapses to it
      sx = px;
      sy = py;
      bbox[0] = px;
      bbox[1] = px;
      bbox[2] = py;
      bbox[3] = py;
    end else begin
      sx = prev_px;
      sy = prev_py;
      if (px < bbox[0]) bbox[0] = px;
      if (px > bbox[1]) bbox[1] = px;
      if (py < bbox[2]) bbox[2] = py;
      if (py > bbox[3]) bbox[3] = py;
    end
    prev_px = px;
    prev_py = py;
    shape_fresh = last;
    r.f[0] = sx[31:0];
    r.f[1] = sy[31:0];
    r.f[2] = px[31:0];
    r.f[3] = py[31:0];
    for (int i = 0; i < 4; i++) r.f[4+i] = bbox[i][31:0];
    r.sat  = sat;
    r.done = last;
  endtask

  // ---------------------------------------------------------------------------
  // Configuration writes, called only while the block is idle
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_ROW_X: row_x_sh = data;
      CFG_ROW_Y: row_y_sh = data;
      CFG_ROW_W: row_w_sh = data;
      CFG_SCALE: scale_sh = data[15:0];
      default: ;
    endcase
  endtask

  task automatic load_view(input logic [63:0] rx, ry, rw, input logic [15:0] sc);
    write_reg(CFG_ROW_X, rx);
    write_reg(CFG_ROW_Y, ry);
    write_reg(CFG_ROW_W, rw);
    write_reg(CFG_SCALE, {48'd0, sc});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Vertex sender: bursts of random length with random gaps between them.
  // Entered and left on a rising edge.
  // ---------------------------------------------------------------------------
  task automatic push_vertex(input logic [31:0] x, y, z, w, input logic last,
                             input bit typed, input seg_box_t typed_r);
    seg_box_t r;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, z, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    project_vertex(x, y, z, w, last, r);
    pending_segs = {pending_segs, (typed ? typed_r : r)};
  endtask

  // Drop valid and wait until every result is back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32 * 65536) - 16 * 65536;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          default: return 32'h1;
        endcase
      end
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  // Half fully random rows, half near a unit coefficient at position k
  function automatic logic [63:0] rand_row(input int k);
    logic [63:0] r;
    if ($urandom_range(0, 1) == 0) return {$urandom, $urandom};
    for (int i = 0; i < 4; i++) r[16*i +: 16] = 16'($urandom_range(0, 16'h0400) - 16'h0200);
    r[16*k +: 16] = 16'(16'h1000 + ($urandom_range(0, 16'h0400) - 16'h0200));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result receiver: stalls on its own pattern, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (holdoff_req != holdoff_served) begin
      holdoff_served++;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0, 1: ready_pct = 100;
          2: ready_pct = 60;
          default: ready_pct = 20;
        endcase
        pattern_left = $urandom_range(50, 600);
      end
      pattern_left--;
      m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Compare each accepted result with the oldest expectation, field by field
  always @(posedge clk_i) begin
    seg_box_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_segs.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = pending_segs.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (m_axis_tdata[32*i +: 32] !== want.f[i])
            report($sformatf("%s got %h want %h", field_name[i],
                             m_axis_tdata[32*i +: 32], want.f[i]));
        end
        if (m_axis_tuser !== want.sat)
          report($sformatf("saturated got %b want %b", m_axis_tuser, want.sat));
        if (m_axis_tlast !== want.done)
          report($sformatf("shape_done got %b want %b", m_axis_tlast, want.done));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    seg_box_t    typed_r;
    logic [63:0] rx, ry, rw;
    logic [15:0] sc;

    // Directed vertices under the reset view (identity rows, unit scale).
    // Simple shapes, all-ones/all-zeros coordinates and zero W have their
    // result written out; tiny, negative and extreme W are predicted.
    dir_rows[0] = '{ONE, 32'h0002_0000, 32'h0, ONE, 1'b0, 1'b1,
                    {32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                     32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000}, 1'b0};
    dir_rows[1] = '{32'h0003_0000, 32'hFFFF_0000, 32'h0005_0000, ONE, 1'b1, 1'b1,
                    {32'h0002_0000, 32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000,
                     32'hFFFF_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000}, 1'b0};
    // zero W: no division, the box follows the raw coordinates
    dir_rows[2] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b1,
                    {32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0};
    dir_rows[3] = '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 1'b1, 1'b1,
                    {32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0};
    dir_rows[4]  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h1, 1'b0, 1'b0,
                     '0, 1'b0};
    dir_rows[5]  = '{ONE, ONE, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0};
    dir_rows[6]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b0, 1'b0,
                     '0, 1'b0};
    dir_rows[7]  = '{32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 32'h7FFF_FFFF, 1'b1, 1'b0,
                     '0, 1'b0};
    dir_rows[8]  = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 1'b0, 1'b0,
                     '0, 1'b0};
    dir_rows[9]  = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333, 1'b1, 1'b0,
                     '0, 1'b0};
    // single-vertex shape
    dir_rows[10] = '{32'hFFFB_0000, 32'h0004_8000, 32'h0, 32'h0000_8000, 1'b1, 1'b0,
                     '0, 1'b0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_r.f    = dir_rows[i].tdata;
      typed_r.sat  = dir_rows[i].sat;
      typed_r.done = dir_rows[i].last;
      push_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].w,
                  dir_rows[i].last, dir_rows[i].typed, typed_r);
    end
    drain();

    // Each phase loads a new view, then streams random polylines through it
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin  // plain perspective: W' = w + z/4
          rx = 64'h0000_0000_0000_1000;
          ry = 64'h0000_0000_1000_0000;
          rw = 64'h1000_0400_0000_0000;
          sc = 16'd256;
        end
        1: begin  // largest positive coefficients, largest scale
          rx = {4{16'h7FFF}};
          ry = {4{16'h7FFF}};
          rw = {4{16'h7FFF}};
          sc = 16'hFFFF;
        end
        2: begin  // most negative coefficients, smallest scale
          rx = {4{16'h8000}};
          ry = {4{16'h8000}};
          rw = {4{16'h8000}};
          sc = 16'd1;
        end
        3: begin  // zero view scale acts as the smallest one
          rx = {4{16'hFFFF}};
          ry = 64'h0000_0000_1000_0000;
          rw = 64'h1000_0000_0000_0000;
          sc = 16'd0;
        end
        4: begin  // all-zero rows: W is always zero
          rx = '0;
          ry = '0;
          rw = '0;
          sc = 16'd256;
        end
        default: begin
          rx = rand_row(0);
          ry = rand_row(1);
          rw = rand_row(3);
          if ($urandom_range(0, 1) == 0) rw[47:32] = 16'($urandom);
          sc = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 16'hFFFF))
                                           : 16'($urandom_range(128, 1024));
        end
      endcase
      load_view(rx, ry, rw, sc);
      // hold off the receiver while the sender keeps offering items
      if (p == 5) holdoff_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_vertex(rand_coord(), rand_coord(), rand_coord(),
                    ($urandom_range(0, 7) == 0) ? 32'h0 : rand_coord(),
                    ($urandom_range(0, 5) == 0), 1'b0, '0);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ppp_pkg.sv
rtl/ppp_div.sv
rtl/ppp_datapath.sv
rtl/ppp_ctrl.sv
rtl/polyline_perspective_projector.sv
rtl/ppp_checker.sv
test/tb_polyline_perspective_projector.sv
